// ===== sv/rar_pkg.sv =====
// Shared types and constants for the rational arithmetic reduction block.
package rar_pkg;

    localparam int InNumW = 16;
    localparam int InDenW = 15;
    localparam int NumW   = 32;
    localparam int DenW   = 31;
    localparam int MagW   = 31;
    localparam int CntW   = $clog2(MagW);
    localparam int InDataW  = 64;
    localparam int OutDataW = 64;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_MUL = 2'd1,
        ACT_INC = 2'd2,
        ACT_DEC = 2'd3
    } t_action;

    // Start request for the GCD and divider units.
    typedef struct packed {
        logic            start;
        logic [MagW-1:0] x;
        logic [MagW-1:0] y;
    } t_unit_req;

    // Completion from a unit; val is valid while done is high.
    typedef struct packed {
        logic            done;
        logic [MagW-1:0] val;
    } t_unit_rsp;

endpackage

// ===== sv/rar_gcd.sv =====
// Iterative binary GCD unit, one shift or subtract step per cycle.
module rar_gcd (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rar_pkg::t_unit_req i_req,
    output rar_pkg::t_unit_rsp o_rsp
);
    import rar_pkg::*;

    logic            r_busy;
    logic            r_done;
    logic [MagW-1:0] r_x;
    logic [MagW-1:0] r_y;
    logic [CntW-1:0] r_k;
    logic [MagW-1:0] r_g;
    logic [MagW-1:0] odd_part;

    assign odd_part = (r_x == '0) ? r_y : r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_x == '0 || r_y == '0);
            if (i_req.start) begin
                r_x    <= i_req.x;
                r_y    <= i_req.y;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x == '0 || r_y == '0) begin
                    // Restore the common factors of two stripped earlier.
                    r_g    <= odd_part << r_k;
                    r_busy <= 1'b0;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.val  = r_g;

endmodule

// ===== sv/rar_div.sv =====
// Restoring divider producing one quotient bit per cycle.
module rar_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rar_pkg::t_unit_req i_req,
    output rar_pkg::t_unit_rsp o_rsp
);
    import rar_pkg::*;

    logic            r_busy;
    logic            r_done;
    logic [MagW-1:0] r_rem;
    logic [MagW-1:0] r_q;
    logic [MagW-1:0] r_dvs;
    logic [CntW-1:0] r_cnt;
    logic [MagW:0]   trial;
    logic            fits;

    assign trial = {r_rem, r_q[MagW-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == '0);
            if (i_req.start) begin
                r_rem  <= '0;
                r_q    <= i_req.x;
                r_dvs  <= i_req.y;
                r_cnt  <= CntW'(MagW - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? MagW'(trial - {1'b0, r_dvs}) : trial[MagW-1:0];
                r_q   <= {r_q[MagW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.val  = r_q;

endmodule

// ===== sv/rational_arith_reduce.sv =====
// Top level of the rational arithmetic block with GCD reduction.
//
// One request on the slave stream carries two fractions a and b (tdata) and an
// action code (tuser): add, multiply, increment a or decrement a. The block
// forms the raw fraction in steps P1 to P3 (add and multiply on one shared
// 17x17 multiplier), then reduces the fraction by the greatest
// common divisor of the absolute numerator and the denominator. The GCD
// unit runs a binary GCD, one shift or subtract per cycle; then the shared
// restoring divider divides numerator and denominator in turn, 31 quotient
// steps each. A zero numerator or a zero denominator skips the reduction.
// The block handles one request at a time: s_axis_tready is high only
// while the sequencer is idle. Results sit in an output register, so a
// stalled master side does not stop the next request from being accepted;
// the sequencer waits at its final step until that register is free.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// m_axis_tvalid; no request in flight survives it.
module rational_arith_reduce (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_num[15:0], a_den[30:16], b_num[46:31], b_den[61:47], zero pad [63:62]
    input  logic [rar_pkg::InDataW-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // res_num[31:0], res_den[62:32], zero pad [63]
    output logic [rar_pkg::OutDataW-1:0] m_axis_tdata,
    // same_raw[0], bad_input[1]
    output logic [1:0]                   m_axis_tuser
);
    import rar_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_PREP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } t_state;

    t_state r_state;

    // Captured request fields.
    t_action            r_act;
    logic [InNumW-1:0]  r_an;
    logic [InDenW-1:0]  r_ad;
    logic [InNumW-1:0]  r_bn;
    logic [InDenW-1:0]  r_bd;
    logic               r_same;
    logic               r_bad;

    // Raw and reduced fraction.
    logic [NumW-1:0]    r_num;
    logic [NumW-1:0]    r_prod;
    logic [DenW-1:0]    r_den;
    logic               r_neg;
    logic [MagW-1:0]    r_g;
    logic [MagW-1:0]    r_magq;
    logic [NumW-1:0]    r_res_num;
    logic [DenW-1:0]    r_res_den;

    // Output register.
    logic               r_m_valid;
    logic [NumW-1:0]    r_m_num;
    logic [DenW-1:0]    r_m_den;
    logic               r_m_same;
    logic               r_m_bad;

    t_unit_req          r_gcd_req;
    t_unit_req          r_div_req;
    t_unit_rsp          gcd_rsp;
    t_unit_rsp          div_rsp;

    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    logic [NumW-1:0]    num_abs;
    logic [NumW-1:0]    an_ext;
    logic [NumW-1:0]    ad_ext;
    logic               in_fire;
    logic               out_free;
    t_action            in_act;
    logic [InDenW-1:0]  in_ad;
    logic [InDenW-1:0]  in_bd;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign in_act   = t_action'(s_axis_tuser);
    assign in_ad    = s_axis_tdata[30:16];
    assign in_bd    = s_axis_tdata[61:47];

    // The single multiplier; its operands follow the sequencer step.
    always_comb begin
        case (r_state)
            ST_P1: begin
                mul_a = {r_an[InNumW-1], r_an};
                mul_b = (r_act == ACT_MUL) ? {r_bn[InNumW-1], r_bn} : {2'b00, r_bd};
            end
            ST_P2: begin
                mul_a = {r_bn[InNumW-1], r_bn};
                mul_b = {2'b00, r_ad};
            end
            default: begin
                mul_a = {2'b00, r_ad};
                mul_b = {2'b00, r_bd};
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign an_ext  = {{(NumW - InNumW){r_an[InNumW-1]}}, r_an};
    assign ad_ext  = {{(NumW - InDenW){1'b0}}, r_ad};
    assign num_abs = r_num[NumW-1] ? (NumW'(0) - r_num) : r_num;

    rar_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_gcd_req),
        .o_rsp   (gcd_rsp)
    );

    rar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_m_valid       <= 1'b0;
            r_gcd_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            // Each unit gets a one-cycle start pulse when its step begins.
            r_gcd_req.start <= (r_state == ST_PREP) && !(r_bad || r_num == '0);
            r_div_req.start <= (r_state == ST_GCD && gcd_rsp.done)
                               || (r_state == ST_DIVN && div_rsp.done);
            // The final step reloads the output register itself.
            if (r_m_valid && m_axis_tready && r_state != ST_OUT) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_act  <= in_act;
                        r_an   <= s_axis_tdata[15:0];
                        r_ad   <= in_ad;
                        r_bn   <= s_axis_tdata[46:31];
                        r_bd   <= in_bd;
                        r_same <= (s_axis_tdata[15:0] == s_axis_tdata[46:31])
                                  && (in_ad == in_bd);
                        r_bad  <= (in_ad == '0)
                                  || ((in_act == ACT_ADD || in_act == ACT_MUL)
                                      && in_bd == '0);
                        r_state <= ST_P1;
                    end
                end
                ST_P1: begin
                    case (r_act)
                        ACT_INC: r_num <= an_ext + ad_ext;
                        ACT_DEC: r_num <= an_ext - ad_ext;
                        default: r_num <= mul_p[NumW-1:0];
                    endcase
                    r_state <= ST_P2;
                end
                ST_P2: begin
                    r_prod  <= mul_p[NumW-1:0];
                    r_state <= ST_P3;
                end
                ST_P3: begin
                    // Add/mul den is the product, else a_den; add sums the cross term.
                    if (r_act == ACT_ADD || r_act == ACT_MUL) begin
                        r_den <= mul_p[DenW-1:0];
                    end else begin
                        r_den <= {{(DenW - InDenW){1'b0}}, r_ad};
                    end
                    if (r_act == ACT_ADD) begin
                        r_num <= r_num + r_prod;
                    end
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    if (r_bad || r_num == '0) begin
                        r_res_num <= '0;
                        r_res_den <= DenW'(1);
                        r_state   <= ST_OUT;
                    end else begin
                        r_neg       <= r_num[NumW-1];
                        r_gcd_req.x <= num_abs[MagW-1:0];
                        r_gcd_req.y <= r_den;
                        r_state     <= ST_GCD;
                    end
                end
                ST_GCD: begin
                    if (gcd_rsp.done) begin
                        r_g         <= gcd_rsp.val;
                        r_div_req.x <= r_gcd_req.x;
                        r_div_req.y <= gcd_rsp.val;
                        r_state     <= ST_DIVN;
                    end
                end
                ST_DIVN: begin
                    if (div_rsp.done) begin
                        r_magq      <= div_rsp.val;
                        r_div_req.x <= r_den;
                        r_div_req.y <= r_g;
                        r_state     <= ST_DIVD;
                    end
                end
                ST_DIVD: begin
                    if (div_rsp.done) begin
                        r_res_den <= div_rsp.val;
                        r_res_num <= r_neg ? (NumW'(0) - {1'b0, r_magq}) : {1'b0, r_magq};
                        r_state   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_num   <= r_res_num;
                        r_m_den   <= r_res_den;
                        r_m_same  <= r_same;
                        r_m_bad   <= r_bad;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_den, r_m_num};
    assign m_axis_tuser  = {r_m_bad, r_m_same};

    // A delivered result always has a nonzero denominator.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[62:32] != '0))
        else $error("result denominator is zero");

    // A rejected input always reports the fraction 0/1.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (m_axis_tdata[31:0] == '0 && m_axis_tdata[62:32] == DenW'(1)))
        else $error("bad input did not give 0/1");

    // Once a request is taken, the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("request accepted while busy");

    // The divider only reports completion while the sequencer waits on it in a divide step.
    a_unit_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIVN || r_state == ST_DIVD))
        else $error("divider completed outside a divide step");

endmodule

// ===== dv/rational_arith_reduce_tb.sv =====
// Self-checking testbench for the rational arithmetic block with GCD reduction.
`timescale 1ns / 1ps

module rational_arith_reduce_tb;

    import rar_pkg::*;

    // One request as the sender sees it, before packing onto the stream.
    typedef struct {
        t_action                  act;
        logic signed [InNumW-1:0] a_num;
        logic [InDenW-1:0]        a_den;
        logic signed [InNumW-1:0] b_num;
        logic [InDenW-1:0]        b_den;
    } t_frac_req;

    // One reduced fraction with its two flags, as it leaves the block.
    typedef struct {
        logic signed [NumW-1:0] num;
        logic [DenW-1:0]        den;
        logic                   same;
        logic                   bad;
    } t_frac_res;

    // Clock, reset and the two stream groups. Every input starts at a known value.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // a_num[15:0], a_den[30:16], b_num[46:31], b_den[61:47], zero pad [63:62]
    logic [InDataW-1:0]  s_axis_tdata = '0;
    // action[1:0]
    logic [1:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // res_num[31:0], res_den[62:32], zero pad [63]
    logic [OutDataW-1:0] m_axis_tdata;
    // same_raw[0], bad_input[1]
    logic [1:0]          m_axis_tuser;

    rational_arith_reduce u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Requests still to be offered, and reduced fractions still owed by the block.
    t_frac_req requests_to_send[$];
    t_frac_res fractions_due[$];
    t_frac_req cur_req;

    int n_total;
    int n_sent;
    int n_accepted;
    int n_checked;
    int n_errors;
    int n_per_action[4];
    int n_bad;
    int n_same;
    int n_zero;

    int gap_left;
    int stall_left;
    int hold_left;
    int next_hold_at = 300;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Reset is held low from the start and released on a falling edge.
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    // Predicts the reduced fraction and both flags for one request. The raw
    // numerator and denominator are formed in 64-bit arithmetic, then divided
    // by the Euclidean GCD of the magnitude and the denominator.
    function automatic t_frac_res reduced_fraction(t_frac_req r);
        longint an;
        longint ad;
        longint bn;
        longint bd;
        longint n;
        longint d;
        longint mag;
        longint x;
        longint y;
        longint t;
        t_frac_res e;
        an = longint'(r.a_num);
        ad = longint'(r.a_den);
        bn = longint'(r.b_num);
        bd = longint'(r.b_den);
        n = 0;
        d = 1;
        e.same = (r.a_num == r.b_num) && (r.a_den == r.b_den);
        // Increment and decrement never look at b, so only a_den can be bad there.
        e.bad = (ad == 0) || ((r.act == ACT_ADD || r.act == ACT_MUL) && bd == 0);
        if (!e.bad) begin
            case (r.act)
                ACT_ADD: begin
                    n = an * bd + bn * ad;
                    d = ad * bd;
                end
                ACT_MUL: begin
                    n = an * bn;
                    d = ad * bd;
                end
                ACT_INC: begin
                    n = an + ad;
                    d = ad;
                end
                default: begin
                    n = an - ad;
                    d = ad;
                end
            endcase
            if (n == 0) begin
                d = 1;
            end else begin
                mag = (n < 0) ? -n : n;
                x = mag;
                y = d;
                while (y != 0) begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                mag = mag / x;
                d = d / x;
                n = (n < 0) ? -mag : mag;
            end
        end
        e.num = n[NumW-1:0];
        e.den = d[DenW-1:0];
        return e;
    endfunction

    function automatic t_frac_req make_req(t_action act, int an, int ad, int bn, int bd);
        t_frac_req r;
        r.act = act;
        r.a_num = an[InNumW-1:0];
        r.a_den = ad[InDenW-1:0];
        r.b_num = bn[InNumW-1:0];
        r.b_den = bd[InDenW-1:0];
        return r;
    endfunction

    // Numerators: full-range noise, small values, values near the extremes,
    // and products of small factors so that reductions are frequent.
    function automatic int rand_num();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            4, 5, 6: v = int'($urandom_range(0, 100)) - 50;
            7: v = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 2))
                                        : -32768 + int'($urandom_range(0, 2));
            default: begin
                v = int'($urandom_range(1, 12)) * int'($urandom_range(1, 2500));
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    // Denominators: mostly legal, a few zero to exercise the error flag.
    function automatic int rand_den();
        int v;
        case ($urandom_range(0, 19))
            0: v = 0;
            1, 2, 3, 4, 5, 6: v = $urandom_range(1, 60);
            7, 8: v = 32767 - int'($urandom_range(0, 3));
            9, 10, 11: v = int'($urandom_range(1, 200)) * int'($urandom_range(1, 100));
            default: v = $urandom_range(1, 32767);
        endcase
        return v;
    endfunction

    function automatic t_frac_req random_request();
        t_frac_req r;
        r = make_req(t_action'($urandom_range(0, 3)), rand_num(), rand_den(),
                     rand_num(), rand_den());
        // Now and then b is a copy of a, so the equality flag is seen often.
        if ($urandom_range(0, 99) < 8) begin
            r.b_num = r.a_num;
            r.b_den = r.a_den;
        end
        return r;
    endfunction

    // Idle lengths: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Sender: presents one request at a time on the falling edge and keeps it
    // until the rising edge that accepts it, then idles for a random gap.
    // Every fourth stretch of 128 requests is sent back to back.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else if (s_axis_tvalid && n_accepted != n_sent) begin
            // The current request has not been taken yet; hold it.
        end else if (gap_left > 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left--;
        end else if (requests_to_send.size() > 0) begin
            cur_req = requests_to_send.pop_front();
            s_axis_tdata <= {2'b00, cur_req.b_den, cur_req.b_num, cur_req.a_den,
                             cur_req.a_num};
            s_axis_tuser <= cur_req.act;
            s_axis_tvalid <= 1'b1;
            n_sent++;
            gap_left = (((n_sent / 128) % 4) == 2) ? 0 : pick_gap();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Long hold-off on the result side. While it lasts the sender keeps
    // offering, so the output register and the sequencer both fill and the
    // block has to drop s_axis_tready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (n_accepted >= next_hold_at && next_hold_at < n_total) begin
            hold_left <= 600;
            next_hold_at <= next_hold_at + 1000;
        end
    end

    // Receiver: random stalls of random length, with calm stretches where it
    // is always ready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (((n_checked / 128) % 4) == 1 || $urandom_range(0, 99) >= 15) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    // Both handshakes are observed on the rising edge. A result is checked
    // against the oldest fraction still due before a newly accepted request
    // adds its own prediction to the back of the store.
    always @(posedge i_clk) begin
        t_frac_res got;
        t_frac_res want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.num = m_axis_tdata[NumW-1:0];
                got.den = m_axis_tdata[NumW+DenW-1:NumW];
                got.same = m_axis_tuser[0];
                got.bad = m_axis_tuser[1];
                if (fractions_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d/%0d", $time,
                             got.num, got.den);
                    n_errors++;
                end else begin
                    want = fractions_due.pop_front();
                    check_field("res_num", longint'(want.num), longint'(got.num));
                    check_field("res_den", longint'(want.den), longint'(got.den));
                    check_field("same_raw", longint'(want.same), longint'(got.same));
                    check_field("bad_input", longint'(want.bad), longint'(got.bad));
                end
                n_checked++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = reduced_fraction(cur_req);
                fractions_due.push_back(want);
                n_per_action[cur_req.act]++;
                if (want.bad) n_bad++;
                if (want.same) n_same++;
                if (!want.bad && want.num == 0) n_zero++;
                n_accepted++;
            end
        end
    end

    initial begin
        // Directed part: every action, the extremes of every field, zero
        // numerators, zero denominators in each position, and equal operands.
        requests_to_send.push_back(make_req(ACT_ADD, 1, 2, 1, 3));
        requests_to_send.push_back(make_req(ACT_ADD, 1, 2, 1, 2));
        requests_to_send.push_back(make_req(ACT_MUL, 2, 3, 3, 4));
        requests_to_send.push_back(make_req(ACT_MUL, -32768, 1, -32768, 1));
        requests_to_send.push_back(make_req(ACT_MUL, 32767, 32767, -32768, 32767));
        requests_to_send.push_back(make_req(ACT_ADD, -32768, 32767, -32768, 32767));
        requests_to_send.push_back(make_req(ACT_ADD, 32767, 1, 32767, 1));
        requests_to_send.push_back(make_req(ACT_ADD, -32768, 1, -32768, 1));
        requests_to_send.push_back(make_req(ACT_ADD, 3, 6, -1, 2));
        requests_to_send.push_back(make_req(ACT_MUL, 0, 5, 7, 3));
        requests_to_send.push_back(make_req(ACT_INC, 3, 4, 9, 9));
        requests_to_send.push_back(make_req(ACT_INC, -5, 5, -32768, 0));
        requests_to_send.push_back(make_req(ACT_DEC, 5, 5, 32767, 32767));
        requests_to_send.push_back(make_req(ACT_DEC, -32768, 32767, 0, 0));
        requests_to_send.push_back(make_req(ACT_DEC, 32767, 1, 1, 1));
        requests_to_send.push_back(make_req(ACT_INC, 32767, 32767, 32767, 32767));
        requests_to_send.push_back(make_req(ACT_INC, 7, 0, 7, 3));
        requests_to_send.push_back(make_req(ACT_DEC, -1, 0, 0, 0));
        requests_to_send.push_back(make_req(ACT_ADD, 5, 0, 5, 7));
        requests_to_send.push_back(make_req(ACT_MUL, 5, 7, 5, 0));
        requests_to_send.push_back(make_req(ACT_ADD, 0, 0, 0, 0));
        requests_to_send.push_back(make_req(ACT_MUL, -1, 32767, -1, 32767));
        requests_to_send.push_back(make_req(ACT_DEC, 0, 1, -32768, 32767));
        for (int i = 0; i < 1850; i++) begin
            requests_to_send.push_back(random_request());
        end
        n_total = requests_to_send.size();

        // Drain: every request taken and every fraction returned, then a
        // quiet tail long enough for one more request's worth of latency.
        while (n_accepted < n_total || fractions_due.size() > 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);

        $display("Ran %0d requests: %0d add, %0d multiply, %0d increment, %0d decrement.",
                 n_accepted, n_per_action[ACT_ADD], n_per_action[ACT_MUL],
                 n_per_action[ACT_INC], n_per_action[ACT_DEC]);
        $display("Checked %0d results: %0d rejected, %0d equal operands, %0d zero, %0d mismatches.",
                 n_checked, n_bad, n_same, n_zero, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
